FILE: rtl/core/band_level_peak_hold_meter_core_assert.svh
// ----------------------------------------------------------------------------
// band level meter assertion macros
// shared property forms for the meter checkers
// ----------------------------------------------------------------------------
`ifndef BAND_LEVEL_PEAK_HOLD_METER_CORE_ASSERT_SVH
`define BAND_LEVEL_PEAK_HOLD_METER_CORE_ASSERT_SVH

// same-cycle implication
`define BLPHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLPHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/blphm_pkg.sv
// ----------------------------------------------------------------------------
// blphm_pkg
// types and constants shared by the band level meter modules
// ----------------------------------------------------------------------------
`default_nettype none

package blphm_pkg;

  localparam int NUM_BANDS = 16;
  localparam int IDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam int LEVEL_W   = 16;
  localparam int HOLD_W    = 8;
  localparam int STEP_W    = 7;
  localparam int BAND_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [STEP_W-1:0]  STEP_GROW_LIMIT = 7'd64;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST  = 16'd0;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 16'd128;
  localparam logic [LEVEL_W-1:0] BAR_DECAY_RST  = 16'd4;
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 8'd8;
  localparam logic [STEP_W-1:0]  INIT_STEP_RST  = 7'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_DECAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP  = 3'd4;

  typedef struct packed {
    logic             wr_en;
    logic             tick_start;
    logic             s1_en;
    logic [IDX_W-1:0] s1_idx;
    logic             s2_en;
    logic [IDX_W-1:0] s2_idx;
    logic             s2_last;
  } blphm_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/band_level_peak_hold_meter_core.sv
// ----------------------------------------------------------------------------
// band_level_peak_hold_meter_core
// multi-band level meter with bar decay and peak hold with falloff
// ----------------------------------------------------------------------------
// A level write (opcode 0) leaves busy low, so writes can be issued back to
// back. A tick (opcode 1) raises busy while the band state is walked one
// band per cycle through a merge stage and a decay stage. Results follow the
// tick start through the sequencer state, the merge stage register and the
// result register, one band per cycle in band order on consecutive cycles,
// each marked by strobe for one cycle only; the receiver has no way to stall
// them and must take every beat.
// The config channel is always ready; writes belong between items.
// ----------------------------------------------------------------------------
`default_nettype none

module band_level_peak_hold_meter_core (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire  [blphm_pkg::BAND_W-1:0]       band,
  input  wire  [blphm_pkg::LEVEL_W-1:0]      level_value,
  input  wire                                commit,
  output logic                               strobe,
  output logic [blphm_pkg::BAND_W-1:0]       out_band,
  output logic [blphm_pkg::LEVEL_W-1:0]      bar_level,
  output logic [blphm_pkg::LEVEL_W-1:0]      peak_level,
  output logic                               last_of_run,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [blphm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [blphm_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import blphm_pkg::*;

  blphm_cmd_t cmd;

  assign cfg_ready = 1'b1;

  blphm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd)
  );

  blphm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .commit      (commit),
    .band        (band),
    .level_value (level_value),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .out_band    (out_band),
    .bar_level   (bar_level),
    .peak_level  (peak_level),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

FILE: rtl/core/blphm_ctrl.sv
// ----------------------------------------------------------------------------
// blphm_ctrl
// sequencer: accepts items and walks the bands through the two-stage datapath
// ----------------------------------------------------------------------------
`default_nettype none

module blphm_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire                     opcode,
  output logic                    busy,
  output blphm_pkg::blphm_cmd_t   cmd
);
  import blphm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANDS - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  logic             s2_en;
  logic [IDX_W-1:0] s2_idx;
  logic             s2_last;
  logic             accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_TICK) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end
      end
      ST_RUN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      s2_en <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      s2_en <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    s2_idx  <= cnt;
    s2_last <= (cnt == LAST_IDX);
  end

  always_comb begin
    cmd.wr_en      = accept && (opcode == OP_WRITE);
    cmd.tick_start = accept && (opcode == OP_TICK);
    cmd.s1_en      = (state == ST_RUN);
    cmd.s1_idx     = cnt;
    cmd.s2_en      = s2_en;
    cmd.s2_idx     = s2_idx;
    cmd.s2_last    = s2_last;
  end

endmodule

`default_nettype wire

FILE: rtl/core/blphm_datapath.sv
// ----------------------------------------------------------------------------
// blphm_datapath
// config registers, band state, merge stage, decay stage and result register
// ----------------------------------------------------------------------------
`default_nettype none

module blphm_datapath (
  input  wire                                    clk,
  input  wire                                    rst,
  input  blphm_pkg::blphm_cmd_t                  cmd,
  input  wire                                    commit,
  input  wire  [blphm_pkg::BAND_W-1:0]           band,
  input  wire  [blphm_pkg::LEVEL_W-1:0]          level_value,
  input  wire                                    cfg_valid,
  input  wire  [blphm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [blphm_pkg::CFG_DAT_W-1:0]        cfg_data,
  output logic                                   strobe,
  output logic [blphm_pkg::BAND_W-1:0]           out_band,
  output logic [blphm_pkg::LEVEL_W-1:0]          bar_level,
  output logic [blphm_pkg::LEVEL_W-1:0]          peak_level,
  output logic                                   last_of_run
);
  import blphm_pkg::*;

  logic [LEVEL_W-1:0] min_level;
  logic [LEVEL_W-1:0] max_level;
  logic [LEVEL_W-1:0] bar_decay_step;
  logic [HOLD_W-1:0]  peak_hold_ticks;
  logic [STEP_W-1:0]  peak_initial_step;

  logic [LEVEL_W-1:0] bar_levels     [NUM_BANDS];
  logic [LEVEL_W-1:0] peak_levels    [NUM_BANDS];
  logic [HOLD_W-1:0]  hold_counts    [NUM_BANDS];
  logic [STEP_W-1:0]  fall_steps     [NUM_BANDS];
  logic [LEVEL_W-1:0] pending_levels [NUM_BANDS];
  logic               pending_ready;
  logic               do_merge;

  logic [LEVEL_W-1:0] s1_bar;
  logic [LEVEL_W-1:0] s1_peak;
  logic [HOLD_W-1:0]  s1_hold;
  logic [STEP_W-1:0]  s1_fall;

  logic [LEVEL_W-1:0] clamped;
  logic [LEVEL_W-1:0] nl;
  logic [LEVEL_W-1:0] m_bar;
  logic [LEVEL_W-1:0] m_peak;
  logic [HOLD_W-1:0]  m_hold;
  logic [STEP_W-1:0]  m_fall;

  logic [LEVEL_W-1:0] d_bar;
  logic [LEVEL_W-1:0] d_peak;
  logic [LEVEL_W-1:0] pk_sub;
  logic [HOLD_W-1:0]  d_hold;
  logic [STEP_W-1:0]  d_fall;
  logic [STEP_W:0]    fall_sum;
  logic [LEVEL_W-1:0] st_wide;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level         <= MIN_LEVEL_RST;
      max_level         <= MAX_LEVEL_RST;
      bar_decay_step    <= BAR_DECAY_RST;
      peak_hold_ticks   <= HOLD_TICKS_RST;
      peak_initial_step <= INIT_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_LEVEL:  min_level         <= cfg_data[LEVEL_W-1:0];
        CFG_MAX_LEVEL:  max_level         <= cfg_data[LEVEL_W-1:0];
        CFG_BAR_DECAY:  bar_decay_step    <= cfg_data[LEVEL_W-1:0];
        CFG_HOLD_TICKS: peak_hold_ticks   <= cfg_data[HOLD_W-1:0];
        CFG_INIT_STEP:  peak_initial_step <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp on write
  always_comb begin
    if (level_value < min_level) begin
      clamped = min_level;
    end else if (level_value > max_level) begin
      clamped = max_level;
    end else begin
      clamped = level_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (32'(band) < NUM_BANDS)) begin
      pending_levels[IDX_W'(band)] <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_ready <= 1'b0;
      do_merge      <= 1'b0;
    end else if (cmd.wr_en) begin
      pending_ready <= commit;
    end else if (cmd.tick_start) begin
      do_merge      <= pending_ready;
      pending_ready <= 1'b0;
    end
  end

  // merge stage
  always_comb begin
    nl     = pending_levels[cmd.s1_idx];
    m_bar  = bar_levels[cmd.s1_idx];
    m_peak = peak_levels[cmd.s1_idx];
    m_hold = hold_counts[cmd.s1_idx];
    m_fall = fall_steps[cmd.s1_idx];
    if (do_merge && nl > m_bar) begin
      m_bar = nl;
    end
    if (do_merge && nl > m_peak) begin
      m_peak = nl;
      m_hold = peak_hold_ticks;
      m_fall = peak_initial_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s1_en) begin
      s1_bar  <= m_bar;
      s1_peak <= m_peak;
      s1_hold <= m_hold;
      s1_fall <= m_fall;
    end
  end

  // decay stage
  always_comb begin
    st_wide  = LEVEL_W'(s1_fall);
    fall_sum = {1'b0, s1_fall} + {2'b00, s1_fall[STEP_W-1:1]};
    d_bar    = (s1_bar >= bar_decay_step) ? (s1_bar - bar_decay_step) : '0;
    pk_sub   = (s1_peak > st_wide) ? (s1_peak - st_wide) : '0;
    d_peak   = s1_peak;
    d_hold   = s1_hold;
    d_fall   = s1_fall;
    if (s1_hold != '0) begin
      d_hold = s1_hold - 1'b1;
    end else begin
      d_peak = (pk_sub <= d_bar) ? d_bar : pk_sub;
      if (s1_fall < STEP_GROW_LIMIT) begin
        d_fall = fall_sum[STEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        bar_levels[i]  <= '0;
        peak_levels[i] <= '0;
        hold_counts[i] <= HOLD_TICKS_RST;
        fall_steps[i]  <= INIT_STEP_RST;
      end
    end else if (cmd.s2_en) begin
      bar_levels[cmd.s2_idx]  <= d_bar;
      peak_levels[cmd.s2_idx] <= d_peak;
      hold_counts[cmd.s2_idx] <= d_hold;
      fall_steps[cmd.s2_idx]  <= d_fall;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.s2_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s2_en) begin
      out_band    <= BAND_W'(cmd.s2_idx);
      bar_level   <= d_bar;
      peak_level  <= d_peak;
      last_of_run <= cmd.s2_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/blphm_checker.sv
// ----------------------------------------------------------------------------
// blphm_checker
// port-level checks on the meter core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "band_level_peak_hold_meter_core_assert.svh"

module blphm_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              start,
  input wire                              busy,
  input wire                              opcode,
  input wire                              strobe,
  input wire [blphm_pkg::BAND_W-1:0]      out_band,
  input wire                              last_of_run
);
  import blphm_pkg::*;

  `BLPHM_ASSERT_NEXT(a_tick_busy, start && !busy && opcode == OP_TICK, busy, "tick did not raise busy")

  `BLPHM_ASSERT_NEXT(a_run_contig, strobe && !last_of_run, strobe, "gap inside a result run")

  `BLPHM_ASSERT_NEXT(a_band_order, strobe && !last_of_run, out_band == $past(out_band) + 4'd1, "result bands out of order")

  `BLPHM_ASSERT_NOW(a_last_band, strobe && last_of_run, out_band == BAND_W'(NUM_BANDS - 1), "last flag on wrong band")

  `BLPHM_ASSERT_NEXT(a_write_quiet, start && !busy && opcode == OP_WRITE, !strobe, "result beat after a level write")

endmodule

bind band_level_peak_hold_meter_core blphm_checker u_blphm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .opcode      (opcode),
  .strobe      (strobe),
  .out_band    (out_band),
  .last_of_run (last_of_run)
);

`default_nettype wire
